// ----- rtl/core/dkn_pkg.sv -----
// shared types and constants for the nearest-target list block
// no dependencies

package dkn_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int TAG_W       = 8;
  localparam int RADIUS_W    = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd500;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    OC_APPENDED   = 2'd0,
    OC_REPLACED   = 2'd1,
    OC_DUPLICATE  = 2'd2,
    OC_NOT_CLOSER = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

endpackage

// ----- rtl/core/dedup_keep_nearest_target_list_top.sv -----
// target list with radius dedup, keeping the targets nearest the robot
// depends on dkn_pkg (entry type, outcome codes, sizes)
//
// usage: offer one target plus the robot position per input beat on in_*;
// one result beat per offer comes out on out_* (outcome, removed slot,
// entry count, first list entry). cfg_we with cfg_wdata sets the dedup
// radius (reset 500), to be written only while the block is idle.
// every distance goes through one shared squaring unit, point by point
// (difference squared for x, then y, then sum and compare), and each entry
// is read from the list memory in a read step of its own before that.
// an offer scans the entries in order, and a duplicate hit stops the scan;
// with room left the offer is appended after the scan. on a full list the
// offer's own distance to the robot is formed, then every entry's, to find the
// farthest; a closer offer removes it, shifts later entries down, is appended.
// in_tready is high only while idle; one offer is worked on at a time, and the
// next offer is taken in the cycle after the result is loaded at the earliest.
// reset empties the list and the output register; the memory is not cleared.
// when the receiver stalls, the result waits in the output register; the block
// takes the next offer and holds in its final step until that beat is taken.

module dedup_keep_nearest_target_list_top
  import dkn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [RADIUS_W-1:0]   cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // item_x, item_y, item_tag, robot_x, robot_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // outcome, removed_slot, entry_count, front_x, front_y, front_tag, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_THR,
    S_DRD, S_DSX, S_DSY, S_DCMP,
    S_NSX, S_NSY, S_NCMP,
    S_FRD, S_FSX, S_FSY, S_FCMP, S_FDEC,
    S_SHRD, S_SHWR, S_APPEND, S_DONE
  } state_t;

  state_t                 state_r;
  logic [RADIUS_W-1:0]    radius_r;
  entry_t                 item_r;
  logic signed [COORD_W-1:0] robot_x_r, robot_y_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       idx_r;
  logic [IDX_W-1:0]       far_idx_r;
  logic [PROD_W-1:0]      prod_r, acc_r, thresh_r, new_d_r, far_d_r;
  outcome_t               outcome_r;
  logic [IDX_W-1:0]       removed_r;
  entry_t                 front_r;
  entry_t                 rd_r;
  entry_t                 entry_mem_r [MAX_ENTRIES];
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;

  // shared distance unit
  logic                   use_rd_a, use_rd_b, use_y;
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [DIFF_W-1:0]  dx, dy, mul_a;
  logic signed [PROD_W-1:0]  mul_p;
  logic [PROD_W-1:0]      dist_sum;

  assign use_rd_a = (state_r == S_FSX) || (state_r == S_FSY);
  assign use_rd_b = (state_r == S_DSX) || (state_r == S_DSY);
  assign use_y    = (state_r == S_DSY) || (state_r == S_NSY) || (state_r == S_FSY);
  assign ax = use_rd_a ? rd_r.x : item_r.x;
  assign ay = use_rd_a ? rd_r.y : item_r.y;
  assign bx = use_rd_b ? rd_r.x : robot_x_r;
  assign by = use_rd_b ? rd_r.y : robot_y_r;
  assign dx = {ax[COORD_W-1], ax} - {bx[COORD_W-1], bx};
  assign dy = {ay[COORD_W-1], ay} - {by[COORD_W-1], by};

  always_comb begin
    if (state_r == S_THR) begin
      mul_a = $signed({{(DIFF_W-RADIUS_W){1'b0}}, radius_r});
    end else if (use_y) begin
      mul_a = dy;
    end else begin
      mul_a = dx;
    end
  end

  assign mul_p    = mul_a * mul_a;
  assign dist_sum = acc_r + prod_r;

  // list memory
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  entry_t                 wr_data;

  assign mem_we  = (state_r == S_SHWR) || (state_r == S_APPEND);
  assign wr_addr = (state_r == S_APPEND) ? cnt_r[IDX_W-1:0] : idx_r;
  assign wr_data = (state_r == S_APPEND) ? item_r : rd_r;
  assign mem_re  = (state_r == S_DRD) || (state_r == S_FRD) || (state_r == S_SHRD);
  assign rd_addr = (state_r == S_SHRD) ? IDX_W'(idx_r + 1'b1) : idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_r <= entry_mem_r[rd_addr];
    end
  end

  // sequencer
  logic [CNT_W-1:0] idx_ext, cnt_m1;
  logic             at_last;
  logic             out_free;
  logic             out_load;

  assign idx_ext  = CNT_W'(idx_r);
  assign cnt_m1   = CNT_W'(cnt_r - 1'b1);
  assign at_last  = (idx_ext == cnt_m1);
  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == S_DONE) && out_free;

  // result beat
  always_comb begin
    out_data_nxt       = '0;
    out_data_nxt[1:0]  = outcome_r;
    out_data_nxt[5:2]  = 4'(removed_r);
    out_data_nxt[10:6] = 5'(cnt_r);
    if (cnt_r != '0) begin
      out_data_nxt[34:11] = front_r.x;
      out_data_nxt[58:35] = front_r.y;
      out_data_nxt[66:59] = front_r.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= RADIUS_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            item_r    <= in_tdata[55:0];
            robot_x_r <= in_tdata[79:56];
            robot_y_r <= in_tdata[103:80];
            idx_r     <= '0;
            removed_r <= '0;
            state_r   <= S_THR;
          end
        end
        S_THR: begin
          thresh_r <= PROD_W'(mul_p);
          if (cnt_r == '0) begin
            outcome_r <= OC_APPENDED;
            state_r   <= S_APPEND;
          end else begin
            state_r <= S_DRD;
          end
        end
        S_DRD: state_r <= S_DSX;
        S_DSX: begin
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_DSY;
        end
        S_DSY: begin
          acc_r   <= prod_r;
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_DCMP;
        end
        S_DCMP: begin
          if (dist_sum < thresh_r) begin
            outcome_r <= OC_DUPLICATE;
            state_r   <= S_DONE;
          end else if (!at_last) begin
            idx_r   <= IDX_W'(idx_r + 1'b1);
            state_r <= S_DRD;
          end else if (cnt_r < CNT_W'(MAX_ENTRIES)) begin
            outcome_r <= OC_APPENDED;
            state_r   <= S_APPEND;
          end else begin
            state_r <= S_NSX;
          end
        end
        S_NSX: begin
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_NSY;
        end
        S_NSY: begin
          acc_r   <= prod_r;
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_NCMP;
        end
        S_NCMP: begin
          new_d_r <= dist_sum;
          idx_r   <= '0;
          state_r <= S_FRD;
        end
        S_FRD: state_r <= S_FSX;
        S_FSX: begin
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_FSY;
        end
        S_FSY: begin
          acc_r   <= prod_r;
          prod_r  <= PROD_W'(mul_p);
          state_r <= S_FCMP;
        end
        S_FCMP: begin
          if ((idx_r == '0) || (dist_sum > far_d_r)) begin
            far_d_r   <= dist_sum;
            far_idx_r <= idx_r;
          end
          if (at_last) begin
            state_r <= S_FDEC;
          end else begin
            idx_r   <= IDX_W'(idx_r + 1'b1);
            state_r <= S_FRD;
          end
        end
        S_FDEC: begin
          if (new_d_r >= far_d_r) begin
            outcome_r <= OC_NOT_CLOSER;
            state_r   <= S_DONE;
          end else begin
            outcome_r <= OC_REPLACED;
            removed_r <= far_idx_r;
            idx_r     <= far_idx_r;
            cnt_r     <= cnt_m1;
            state_r   <= S_SHRD;
          end
        end
        S_SHRD: begin
          if (idx_ext == cnt_r) begin
            state_r <= S_APPEND;
          end else begin
            state_r <= S_SHWR;
          end
        end
        S_SHWR: begin
          if (idx_r == '0) begin
            front_r <= rd_r;
          end
          idx_r   <= IDX_W'(idx_r + 1'b1);
          state_r <= S_SHRD;
        end
        S_APPEND: begin
          if (cnt_r == '0) begin
            front_r <= item_r;
          end
          cnt_r   <= CNT_W'(cnt_r + 1'b1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
